>>> sv/crt3_pkg.sv
// ---------------------------------------------------------------------------
// crt3_pkg
// constants for the three-modulus crt merge: primes, inverses, widths
// ---------------------------------------------------------------------------
package crt3_pkg;

   localparam int RES_W = 30;   // residue width
   localparam int MD_W  = 31;   // output modulus width
   localparam int PAIR_W = 60;  // width of a value below p0*p1
   localparam int FULL_W = 90;  // width of a value below p0*p1*p2

   localparam logic [RES_W-1:0] CRT_P0 = 30'd998244353;
   localparam logic [RES_W-1:0] CRT_P1 = 30'd1004535809;
   localparam logic [RES_W-1:0] CRT_P2 = 30'd1045430273;

   // p0^-1 mod p1 and (p0*p1)^-1 mod p2
   localparam logic [RES_W-1:0] CRT_INV_P0_P1 = 30'd669690699;
   localparam logic [RES_W-1:0] CRT_INV_M_P2  = 30'd942377029;

   // m = p0*p1, split in two 30-bit halves for the final product
   localparam logic [63:0] CRT_M = 64'(CRT_P0) * 64'(CRT_P1);
   localparam logic [RES_W-1:0] CRT_M_LO = CRT_M[29:0];
   localparam logic [RES_W-1:0] CRT_M_HI = CRT_M[59:30];

   localparam logic [MD_W-1:0] MD_RESET = 31'd23333333;

   // bits retired per pipeline stage in the remainder units
   localparam int RED_STEP = 6;

endpackage

>>> sv/crt3_modred.sv
// ---------------------------------------------------------------------------
// crt3_modred
// pipelined restoring reduction: val_in mod mod_in, STEP bits per stage
// ---------------------------------------------------------------------------
module crt3_modred #(
   parameter int IN_W   = 60,
   parameter int MOD_W  = 30,
   parameter int SIDE_W = 1,
   parameter int STEP   = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_in,
   input  logic [IN_W-1:0]   val_in,
   input  logic [MOD_W-1:0]  mod_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              vld_out,
   output logic [MOD_W-1:0]  rem_out,
   output logic [SIDE_W-1:0] side_out
);

   localparam int NS = (IN_W + STEP - 1) / STEP;
   localparam int PW = NS * STEP;

   // retire STEP bits msb first, remainder stays below the modulus
   function automatic logic [MOD_W-1:0] red_step(input logic [MOD_W-1:0] r_in,
                                                 input logic [STEP-1:0]  bits,
                                                 input logic [MOD_W-1:0] m);
      logic [MOD_W:0]   t;
      logic [MOD_W-1:0] r;
      r = r_in;
      for (int j = 0; j < STEP; j++) begin
         t = {r, bits[STEP-1-j]};
         if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
         end
         r = t[MOD_W-1:0];
      end
      return r;
   endfunction

   logic              vld_ff  [NS];
   logic [MOD_W-1:0]  rem_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic [PW-1:0]     val_ff  [NS-1];
   logic [MOD_W-1:0]  mod_ff  [NS-1];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic              vld_src;
      logic [MOD_W-1:0]  rem_src;
      logic [SIDE_W-1:0] side_src;
      logic [PW-1:0]     val_src;
      logic [MOD_W-1:0]  mod_src;

      if (s == 0) begin : g_first
         assign vld_src  = vld_in;
         assign rem_src  = '0;
         assign side_src = side_in;
         assign val_src  = PW'(val_in);
         assign mod_src  = mod_in;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign side_src = side_ff[s-1];
         assign val_src  = val_ff[s-1];
         assign mod_src  = mod_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= red_step(rem_src, val_src[PW-1 -: STEP], mod_src);
            side_ff[s] <= side_src;
         end
      end

      if (s < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               val_ff[s] <= val_src << STEP;
               mod_ff[s] <= mod_src;
            end
         end
      end
   end

   assign vld_out  = vld_ff[NS-1];
   assign rem_out  = rem_ff[NS-1];
   assign side_out = side_ff[NS-1];

endmodule

>>> sv/three_modulus_crt_merge_core.sv
// ---------------------------------------------------------------------------
// three_modulus_crt_merge_core
// merges residues mod 998244353, 1004535809, 1045430273 into x mod csr modulus
// ---------------------------------------------------------------------------
//  channel  dir  signals                         contents
//  req      in   req_tvalid/tready/tdata[95:0]   residue_first, second, third
//  rsp      out  rsp_tvalid/tready/tdata[31:0]   merged_value
//  csr      in   csr_wr_en, csr_wr_data[30:0]    output_modulus
//
//  one request per cycle while the pipe is not stalled
//  the pipe is built from the four remainder units, 6 bits per stage each
//  (60, 60, 60 and 90 bit dividends) plus the multiply and add stages
//  a stalled rsp_tready freezes the whole pipe, req_tready follows it
//  synchronous reset clears the valid bits and loads modulus 23333333
//  modulus zero gives merged_value zero
// ---------------------------------------------------------------------------
module three_modulus_crt_merge_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // residue_first [29:0], residue_second [59:30], residue_third [89:60], zeros
   input  logic [95:0]             req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // merged_value [30:0], zero
   output logic [31:0]             rsp_tdata,
   input  logic                    csr_wr_en,
   input  logic [crt3_pkg::MD_W-1:0] csr_wr_data
);

   import crt3_pkg::*;

   // global advance: the pipe moves unless a result sits unread
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // output modulus register
   logic [MD_W-1:0] md_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         md_ff <= MD_RESET;
      end else if (csr_wr_en) begin
         md_ff <= csr_wr_data;
      end
   end

   // input capture
   logic             in_vld_ff;
   logic [RES_W-1:0] in_r0_ff, in_r1_ff, in_r2_ff;

   // s1: residues reduced below their primes (input < 2p)
   logic             s1_vld_ff;
   logic [RES_W-1:0] s1_r0_ff, s1_r1_ff, s1_r2_ff;
   logic [RES_W-1:0] s1_r0_in, s1_r1_in, s1_r2_in;

   // s2: (r1 - r0) mod p1
   logic             s2_vld_ff;
   logic [RES_W-1:0] s2_d_ff, s2_r0_ff, s2_r2_ff;
   logic [RES_W:0]   s2_sum;
   logic [RES_W-1:0] s2_d_in;

   // s3: times p0^-1, reduced mod p1 in unit a
   logic              s3_vld_ff;
   logic [PAIR_W-1:0] s3_prod_ff;
   logic [RES_W-1:0]  s3_r0_ff, s3_r2_ff;

   logic                  ra_vld;
   logic [RES_W-1:0]      ra_u;
   logic [2*RES_W-1:0]    ra_side;

   // s4/s5: a = r0 + p0*u, the value mod p0*p1
   logic              s4_vld_ff, s5_vld_ff;
   logic [PAIR_W-1:0] s4_pb_ff, s5_a_ff;
   logic [RES_W-1:0]  s4_r0_ff, s4_r2_ff, s5_r2_ff;

   logic                     rb_vld;
   logic [RES_W-1:0]         rb_a2;
   logic [PAIR_W+RES_W-1:0]  rb_side;

   // s6/s7: k = (r2 - a) * m^-1 mod p2, reduced in unit c
   logic              s6_vld_ff, s7_vld_ff;
   logic [RES_W-1:0]  s6_e_ff;
   logic [RES_W:0]    s6_sum;
   logic [RES_W-1:0]  s6_e_in;
   logic [PAIR_W-1:0] s6_a_ff, s7_prod_ff, s7_a_ff;

   logic              rc_vld;
   logic [RES_W-1:0]  rc_k;
   logic [PAIR_W-1:0] rc_side;

   // s8..s10: x = k*m + a, built from two 30x30 products
   logic              s8_vld_ff, s9_vld_ff, s10_vld_ff;
   logic [PAIR_W-1:0] s8_plo_ff, s8_phi_ff, s8_a_ff, s9_phi_ff;
   logic [PAIR_W:0]   s9_x1_ff;
   logic [FULL_W-1:0] s10_x_ff;

   logic              rd_vld;
   logic [MD_W-1:0]   rd_rem;
   logic              rd_zero;

   // output register
   logic              rsp_vld_ff;
   logic [MD_W-1:0]   rsp_data_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff  <= req_tvalid;
         s1_vld_ff  <= in_vld_ff;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= ra_vld;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= rb_vld;
         s7_vld_ff  <= s6_vld_ff;
         s8_vld_ff  <= rc_vld;
         s9_vld_ff  <= s8_vld_ff;
         s10_vld_ff <= s9_vld_ff;
         rsp_vld_ff <= rd_vld;
      end
   end

   // single conditional subtract, all residue fields are below 2p
   always_comb begin
      s1_r0_in = (in_r0_ff >= CRT_P0) ? in_r0_ff - CRT_P0 : in_r0_ff;
      s1_r1_in = (in_r1_ff >= CRT_P1) ? in_r1_ff - CRT_P1 : in_r1_ff;
      s1_r2_in = (in_r2_ff >= CRT_P2) ? in_r2_ff - CRT_P2 : in_r2_ff;
      // r0 < p0 < p1, so r1 + p1 - r0 lies in (0, 2p1)
      s2_sum   = {1'b0, s1_r1_ff} + {1'b0, CRT_P1} - {1'b0, s1_r0_ff};
      s2_d_in  = (s2_sum >= {1'b0, CRT_P1}) ? RES_W'(s2_sum - {1'b0, CRT_P1})
                                            : RES_W'(s2_sum);
      s6_sum   = {1'b0, rb_side[RES_W-1:0]} + {1'b0, CRT_P2} - {1'b0, rb_a2};
      s6_e_in  = (s6_sum >= {1'b0, CRT_P2}) ? RES_W'(s6_sum - {1'b0, CRT_P2})
                                            : RES_W'(s6_sum);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         in_r0_ff    <= req_tdata[29:0];
         in_r1_ff    <= req_tdata[59:30];
         in_r2_ff    <= req_tdata[89:60];
         s1_r0_ff    <= s1_r0_in;
         s1_r1_ff    <= s1_r1_in;
         s1_r2_ff    <= s1_r2_in;
         s2_d_ff     <= s2_d_in;
         s2_r0_ff    <= s1_r0_ff;
         s2_r2_ff    <= s1_r2_ff;
         s3_prod_ff  <= PAIR_W'(s2_d_ff) * PAIR_W'(CRT_INV_P0_P1);
         s3_r0_ff    <= s2_r0_ff;
         s3_r2_ff    <= s2_r2_ff;
         s4_pb_ff    <= PAIR_W'(ra_u) * PAIR_W'(CRT_P0);
         s4_r0_ff    <= ra_side[RES_W-1:0];
         s4_r2_ff    <= ra_side[2*RES_W-1:RES_W];
         s5_a_ff     <= s4_pb_ff + PAIR_W'(s4_r0_ff);
         s5_r2_ff    <= s4_r2_ff;
         s6_e_ff     <= s6_e_in;
         s6_a_ff     <= rb_side[PAIR_W+RES_W-1:RES_W];
         s7_prod_ff  <= PAIR_W'(s6_e_ff) * PAIR_W'(CRT_INV_M_P2);
         s7_a_ff     <= s6_a_ff;
         s8_plo_ff   <= PAIR_W'(rc_k) * PAIR_W'(CRT_M_LO);
         s8_phi_ff   <= PAIR_W'(rc_k) * PAIR_W'(CRT_M_HI);
         s8_a_ff     <= rc_side;
         s9_x1_ff    <= {1'b0, s8_plo_ff} + {1'b0, s8_a_ff};
         s9_phi_ff   <= s8_phi_ff;
         s10_x_ff    <= {s9_phi_ff, {RES_W{1'b0}}} + FULL_W'(s9_x1_ff);
         rsp_data_ff <= rd_zero ? '0 : rd_rem;
      end
   end

   // unit a: u = (r1 - r0) * p0^-1 mod p1
   crt3_modred #(
      .IN_W   (PAIR_W),
      .MOD_W  (RES_W),
      .SIDE_W (2*RES_W),
      .STEP   (RED_STEP)
   ) u_red_a (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (s3_vld_ff),
      .val_in   (s3_prod_ff),
      .mod_in   (CRT_P1),
      .side_in  ({s3_r2_ff, s3_r0_ff}),
      .vld_out  (ra_vld),
      .rem_out  (ra_u),
      .side_out (ra_side)
   );

   // unit b: a mod p2
   crt3_modred #(
      .IN_W   (PAIR_W),
      .MOD_W  (RES_W),
      .SIDE_W (PAIR_W+RES_W),
      .STEP   (RED_STEP)
   ) u_red_b (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (s5_vld_ff),
      .val_in   (s5_a_ff),
      .mod_in   (CRT_P2),
      .side_in  ({s5_a_ff, s5_r2_ff}),
      .vld_out  (rb_vld),
      .rem_out  (rb_a2),
      .side_out (rb_side)
   );

   // unit c: k mod p2
   crt3_modred #(
      .IN_W   (PAIR_W),
      .MOD_W  (RES_W),
      .SIDE_W (PAIR_W),
      .STEP   (RED_STEP)
   ) u_red_c (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (s7_vld_ff),
      .val_in   (s7_prod_ff),
      .mod_in   (CRT_P2),
      .side_in  (s7_a_ff),
      .vld_out  (rc_vld),
      .rem_out  (rc_k),
      .side_out (rc_side)
   );

   // unit d: x mod output modulus; the user must change the modulus only while idle, the block does not enforce it
   crt3_modred #(
      .IN_W   (FULL_W),
      .MOD_W  (MD_W),
      .SIDE_W (1),
      .STEP   (RED_STEP)
   ) u_red_d (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (s10_vld_ff),
      .val_in   (s10_x_ff),
      .mod_in   (md_ff),
      .side_in  (md_ff == '0),
      .vld_out  (rd_vld),
      .rem_out  (rd_rem),
      .side_out (rd_zero)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // residues after the first stage sit below their primes
   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> (s1_r0_ff < CRT_P0) && (s1_r1_ff < CRT_P1) && (s1_r2_ff < CRT_P2))
      else $error("residue not reduced");

   // the coefficient k comes out of unit c below p2
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      rc_vld |-> rc_k < CRT_P2)
      else $error("k out of range");

   // a result is always below a nonzero modulus
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (md_ff != '0) |-> rsp_data_ff < md_ff)
      else $error("merged value not below modulus");

   // modulus zero forces a zero result
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (md_ff == '0) |-> rsp_data_ff == '0)
      else $error("nonzero result for modulus zero");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for three_modulus_crt_merge_core: residue triples go in
// with random bursts and gaps, merged values are checked in order against a
// behavioral crt predictor while the result side stalls on its own pattern
// ---------------------------------------------------------------------------
module tb_top;
   import crt3_pkg::*;

   localparam int PIPE_LAT = 56;   // drain margin for wait_drained

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [95:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;
   logic                csr_wr_en = 1'b0;
   logic [MD_W-1:0]     csr_wr_data = '0;

   always #5 clock = ~clock;

   three_modulus_crt_merge_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: the modulus the core should hold right now
   logic [MD_W-1:0]     merge_mod;
   logic [MD_W-1:0]     expected_merge_q[$];
   int                  fail_count = 0;
   int                  burst_left = 0;
   int                  stall_style = 0;   // 0 always ready, 1 light, 2 heavy

   // x mod merge_mod from the three residues, never forming x itself
   function automatic logic [MD_W-1:0] predict_merged_value(
      logic [RES_W-1:0] r0_in, logic [RES_W-1:0] r1_in, logic [RES_W-1:0] r2_in,
      logic [MD_W-1:0] md);
      logic [127:0] p0, p1, p2, m_pair, r0, r1, r2, t0, t1, pair, k, acc;
      p0 = 128'(998244353);
      p1 = 128'(1004535809);
      p2 = 128'(1045430273);
      m_pair = p0 * p1;
      // out-of-range residues only count by their congruence class
      r0 = 128'(r0_in) % p0;
      r1 = 128'(r1_in) % p1;
      r2 = 128'(r2_in) % p2;
      t0 = (r0 * 128'(332747959)) % p0;
      t1 = (r1 * 128'(669690699)) % p1;
      pair = (t0 * p1 + t1 * p0) % m_pair;
      k = (r2 + p2 - pair % p2) % p2;
      k = (k * 128'(942377029)) % p2;
      if (md == '0) begin
         return '0;
      end
      acc = ((k % 128'(md)) * (m_pair % 128'(md))) % 128'(md);
      acc = (acc + pair % 128'(md)) % 128'(md);
      return acc[MD_W-1:0];
   endfunction

   // result side stall pattern, changes at the falling edge
   always @(negedge clock) begin
      case (stall_style)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            // long stretches of stall with short ready windows
            if (rsp_tready) rsp_tready <= ($urandom_range(0, 2) != 0);
            else            rsp_tready <= ($urandom_range(0, 5) == 0);
         end
      endcase
   end

   // result checker, oldest expectation first
   always @(posedge clock) begin
      logic [MD_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_merge_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_merge_q.pop_front();
            if (rsp_tdata[MD_W-1:0] !== want || rsp_tdata[31] !== 1'b0) begin
               $display("%0t: merged_value mismatch, expected %0d, actual %0d",
                        $time, want, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   // one request: bursts of random length, random gaps in between
   task automatic send_request(logic [RES_W-1:0] r0, logic [RES_W-1:0] r1,
                               logic [RES_W-1:0] r2);
      int gap;
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tdata = {6'b0, r2, r1, r0};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_merge_q.push_back(predict_merged_value(r0, r1, r2, merge_mod));
      @(negedge clock);
   endtask

   // drain everything in flight, then let the pipe empty fully
   task automatic wait_drained();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (expected_merge_q.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 8) @(negedge clock);
   endtask

   task automatic write_modulus(logic [MD_W-1:0] value);
      wait_drained();
      csr_wr_data = value;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      merge_mod = value;
   endtask

   function automatic logic [RES_W-1:0] rand_residue(logic [RES_W-1:0] prime);
      // mostly canonical residues, some anywhere in the 30-bit field
      if ($urandom_range(0, 4) == 0) return RES_W'($urandom);
      return RES_W'($urandom_range(0, prime - 1));
   endfunction

   // extremes of each residue, exact primes and all-ones fields
   task automatic test_residue_extremes();
      send_request('0, '0, '0);
      send_request(CRT_P0 - 1, CRT_P1 - 1, CRT_P2 - 1);
      send_request(CRT_P0, CRT_P1, CRT_P2);
      send_request('1, '1, '1);
      send_request(30'd1, '0, '0);
      send_request('0, 30'd1, '0);
      send_request('0, '0, 30'd1);
      send_request(CRT_P0 + 1, '0, CRT_P2 - 1);
      send_request(30'd5, 30'd5, 30'd5);   // small x, same residue everywhere
      send_request(30'h2AAAAAAA, 30'h15555555, 30'h2AAAAAAA);
      send_request(30'h15555555, 30'h2AAAAAAA, 30'h15555555);
   endtask

   // degenerate and extreme moduli, each with a few items
   task automatic test_modulus_settings();
      logic [MD_W-1:0] mods[5];
      mods = '{31'd0, 31'd1, 31'd2, 31'h7FFFFFFF, 31'd1000000007};
      foreach (mods[i]) begin
         write_modulus(mods[i]);
         send_request(CRT_P0 - 1, CRT_P1 - 1, CRT_P2 - 1);
         send_request('1, '1, '1);
         send_request(30'd7, 30'd7, 30'd7);
         repeat (2) send_request(rand_residue(CRT_P0), rand_residue(CRT_P1),
                                 rand_residue(CRT_P2));
      end
   endtask

   // random residues over several moduli and stall styles
   task automatic test_random_stream();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) write_modulus(MD_RESET);
         else write_modulus(($urandom_range(0, 2) == 0) ? MD_W'($urandom_range(2, 1000))
                                                          : MD_W'($urandom));
         stall_style = phase % 3;
         for (int n = 0; n < 65; n++) begin
            // hold off mid-phase until every response is back
            if (n == 30) wait_drained();
            send_request(rand_residue(CRT_P0), rand_residue(CRT_P1),
                         rand_residue(CRT_P2));
         end
      end
   endtask

   initial begin
      merge_mod = MD_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      stall_style = 1;
      test_residue_extremes();     // runs on the reset modulus
      stall_style = 2;
      test_modulus_settings();
      test_random_stream();
      wait_drained();
      if (fail_count == 0) begin
         $display("[three_modulus_crt_merge_core] OK");
      end else begin
         $display("[three_modulus_crt_merge_core] ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[three_modulus_crt_merge_core] ERROR");
      $finish;
   end

endmodule
